// ===== sv/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg: shared constants and tables for the twist to steer wheel core
// widths, fixed-point scales, reciprocal constants and the arctangent table
// ----------------------------------------------------------------------------
package tsw_pkg;

  // number of cordic micro-rotations, capped at the table length
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN   = 24;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > ATAN_TABLE_LEN) ?
                                    ATAN_TABLE_LEN : ANGLE_ITERATIONS;

  // field widths
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 13;
  localparam int WB_W    = 16;
  // lateral term magnitude stays below 2^21
  localparam int TERM_W  = 22;
  // cordic x/y carry the 2^24 scale plus gain headroom
  localparam int FRAC_W  = 24;
  localparam int XY_W    = 48;
  // angle accumulator in nanoradians
  localparam int Z_W     = 34;

  localparam logic signed [Z_W-1:0] HALF_PI_NRAD = 34'sd1570796327;
  localparam logic [ANGLE_W-2:0]    ANGLE_LIMIT  = 12'd3142;

  // term: |p|/2000 = (|p|>>4)/125, reciprocal floor(2^34/125)
  localparam int             TDIV_PRE   = 4;
  localparam int             TDIV_A_W   = 28;
  localparam int             TDIV_M_W   = 28;
  localparam int             TDIV_SHIFT = 34;
  localparam logic [TDIV_M_W-1:0] TDIV_M   = 28'd137438953;
  localparam logic [6:0]          TDIV_DEN = 7'd125;

  // angle: |z|/1e6 = (|z|>>6)/15625, reciprocal floor(2^40/15625)
  localparam int             ZDIV_PRE   = 6;
  localparam int             ZDIV_A_W   = 26;
  localparam int             ZDIV_M_W   = 27;
  localparam int             ZDIV_SHIFT = 40;
  localparam logic [ZDIV_M_W-1:0] ZDIV_M   = 27'd70368744;
  localparam logic [13:0]         ZDIV_DEN = 14'd15625;

  // register map
  localparam int             CFG_ADDR_W = 3;
  localparam logic           REG_WHEEL_BASE = 1'b0;  // word index bit
  localparam logic [WB_W-1:0] WHEEL_BASE_RESET = 16'd500;

  // arctangent of 2^-i in nanoradians, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_nrad(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd785398163;
      5'd1:    v = 34'sd463647609;
      5'd2:    v = 34'sd244978663;
      5'd3:    v = 34'sd124354995;
      5'd4:    v = 34'sd62418810;
      5'd5:    v = 34'sd31239833;
      5'd6:    v = 34'sd15623729;
      5'd7:    v = 34'sd7812341;
      5'd8:    v = 34'sd3906230;
      5'd9:    v = 34'sd1953123;
      5'd10:   v = 34'sd976562;
      5'd11:   v = 34'sd488281;
      5'd12:   v = 34'sd244141;
      5'd13:   v = 34'sd122070;
      5'd14:   v = 34'sd61035;
      5'd15:   v = 34'sd30518;
      5'd16:   v = 34'sd15259;
      5'd17:   v = 34'sd7629;
      5'd18:   v = 34'sd3815;
      5'd19:   v = 34'sd1907;
      5'd20:   v = 34'sd954;
      5'd21:   v = 34'sd477;
      5'd22:   v = 34'sd238;
      5'd23:   v = 34'sd119;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/twist_to_steer_wheel_commands_core.sv =====
// ----------------------------------------------------------------------------
// twist_to_steer_wheel_commands_core: two-wheel steering inverse kinematics
// body twist in, front/rear wheel speeds and steering angles out
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                        | payload
//  in_      | slave     | in_tvalid / in_tready            | forward_speed, yaw_rate
//  out_     | master    | out_tvalid / out_tready          | angles and speeds
//  cfg_     | apb slave | psel/penable/pwrite, pready = 1  | wheel_base_mm at 0x0
//
// one transaction per cycle sustained while the output is not stalled; the pipe
// depth is set by the one-rotation-per-stage cordic lanes
// rst_n is synchronous: it clears the valid chain and loads wheel base 500
// the pipeline stalls as one: every stage, empty ones included, holds while
// the output waits, and in_tready stays low for the whole stall
// ----------------------------------------------------------------------------
module twist_to_steer_wheel_commands_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave side
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // forward_speed[15:0], yaw_rate[31:16]
  // master side
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // front_angle[12:0], front_speed[28:13],
                                                      // rear_angle[41:29], rear_speed[57:42]
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tsw_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int N     = tsw_pkg::CORDIC_STEPS;
  localparam int DEPTH = N + 6;
  localparam int SW    = tsw_pkg::SPEED_W;
  localparam int TW    = tsw_pkg::TERM_W;

  // ---------------------------------------------------------------- config
  logic [tsw_pkg::WB_W-1:0] wheel_base_r;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_base_r <= tsw_pkg::WHEEL_BASE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == tsw_pkg::REG_WHEEL_BASE)) begin
      wheel_base_r <= cfg_pwdata[tsw_pkg::WB_W-1:0];
    end
  end

  // low address bits are byte lanes and are ignored
  assign cfg_prdata = (cfg_paddr[2] == tsw_pkg::REG_WHEEL_BASE) ?
                      {{(32-tsw_pkg::WB_W){1'b0}}, wheel_base_r} : 32'd0;

  // ---------------------------------------------------------- flow control
  logic [DEPTH-1:0] v_r;
  logic             en;

  // whole pipe moves unless the output holds a transaction nobody takes
  assign en        = !v_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_tvalid};
    end
  end

  // -------------------------------------------- stage 1: yaw * wheel base
  logic signed [SW-1:0] in_fwd, in_yaw;
  logic signed [16:0]   yaw_ext, wb_ext;
  logic signed [33:0]   yw_prod;
  logic signed [32:0]   p_r;
  logic signed [SW-1:0] fwd1_r;

  assign in_fwd  = in_tdata[15:0];
  assign in_yaw  = in_tdata[31:16];
  assign yaw_ext = {in_yaw[SW-1], in_yaw};
  assign wb_ext  = {1'b0, wheel_base_r};
  assign yw_prod = yaw_ext * wb_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= yw_prod[32:0];
      fwd1_r <= in_fwd;
    end
  end

  // ----------------------- stage 2: |p|/16 times reciprocal of 125
  logic [32:0]                                      p_mag;
  logic [tsw_pkg::TDIV_A_W-1:0]                     ta;
  logic [tsw_pkg::TDIV_A_W-1:0]                     ta_r;
  logic [tsw_pkg::TDIV_A_W+tsw_pkg::TDIV_M_W-1:0]   tprod_r;
  logic                                             tneg_r;
  logic signed [SW-1:0]                             fwd2_r;

  assign p_mag = p_r[32] ? -p_r : p_r;
  assign ta    = p_mag[tsw_pkg::TDIV_PRE +: tsw_pkg::TDIV_A_W];

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r    <= ta;
      tprod_r <= ta * tsw_pkg::TDIV_M;
      tneg_r  <= p_r[32];
      fwd2_r  <= fwd1_r;
    end
  end

  // ------------- stage 3: quotient fix-up, sign back -> lateral term
  localparam int TQ_W = tsw_pkg::TDIV_A_W + tsw_pkg::TDIV_M_W - tsw_pkg::TDIV_SHIFT;

  logic [TQ_W-1:0]                tq_est, tq_fix;
  logic [tsw_pkg::TDIV_A_W:0]     trem;
  logic signed [TW-1:0]           term_nxt, term_r;
  logic signed [SW-1:0]           fwd3_r;

  always_comb begin
    tq_est = tprod_r[tsw_pkg::TDIV_SHIFT +: TQ_W];
    trem   = {1'b0, ta_r} - ((tsw_pkg::TDIV_A_W+1)'(tq_est) *
                             (tsw_pkg::TDIV_A_W+1)'(tsw_pkg::TDIV_DEN));
    tq_fix = (trem >= (tsw_pkg::TDIV_A_W+1)'(tsw_pkg::TDIV_DEN)) ? tq_est + 1'b1 : tq_est;
    // truncation toward zero: divide the magnitude, then negate
    term_nxt = tneg_r ? -$signed(tq_fix) : $signed(tq_fix);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      fwd3_r <= fwd2_r;
    end
  end

  // ------------------------- stage 4: saturated wheel speeds, delay line
  logic signed [TW:0]   front_sum, rear_sum;
  logic signed [SW-1:0] front_sat, rear_sat;
  logic signed [SW-1:0] front_spd_r [0:N+2];
  logic signed [SW-1:0] rear_spd_r  [0:N+2];
  logic signed [TW-1:0] term_neg;

  function automatic logic signed [SW-1:0] sat16(input logic signed [TW:0] v);
    logic signed [SW-1:0] r;
    if (v > (TW+1)'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -(TW+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  assign term_neg  = -term_r;
  assign front_sum = (TW+1)'(fwd3_r) + (TW+1)'(term_r);
  assign rear_sum  = (TW+1)'(fwd3_r) - (TW+1)'(term_r);
  assign front_sat = sat16(front_sum);
  assign rear_sat  = sat16(rear_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      front_spd_r[0] <= front_sat;
      rear_spd_r[0]  <= rear_sat;
      for (int k = 1; k <= N + 2; k++) begin
        front_spd_r[k] <= front_spd_r[k-1];
        rear_spd_r[k]  <= rear_spd_r[k-1];
      end
    end
  end

  // ------------------------------- stages 4..N+6: steering angle lanes
  logic signed [tsw_pkg::ANGLE_W-1:0] front_angle, rear_angle;

  tsw_cordic_lane u_front (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd3_r),
    .lat   (term_r),
    .angle (front_angle)
  );

  tsw_cordic_lane u_rear (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd3_r),
    .lat   (term_neg),
    .angle (rear_angle)
  );

  // ----------------------------------------------------------------- output
  assign out_tvalid = v_r[DEPTH-1];
  assign out_tdata  = {6'd0, rear_spd_r[N+2], rear_angle, front_spd_r[N+2], front_angle};

`ifndef NO_ASSERTIONS
  // an accepted transaction enters the valid chain
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted transaction not in first stage");

  // a stall freezes every stage's valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid chain moved during a stall");

  // a valid stage hands its transaction on when the pipe moves
  a_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[0] |=> v_r[1])
    else $error("transaction lost in the pipeline");

  // steering angles stay inside the clamp
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[12:0]) <= 13'sd3142) &&
                   ($signed(out_tdata[12:0]) >= -13'sd3142) &&
                   ($signed(out_tdata[41:29]) <= 13'sd3142) &&
                   ($signed(out_tdata[41:29]) >= -13'sd3142))
    else $error("steering angle outside clamp");

  // a wheel base write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[2] == tsw_pkg::REG_WHEEL_BASE) |=>
      wheel_base_r == $past(cfg_pwdata[tsw_pkg::WB_W-1:0]))
    else $error("wheel base write lost");
`endif

endmodule

// ===== sv/tsw_cordic_lane.sv =====
// ----------------------------------------------------------------------------
// tsw_cordic_lane: pipelined vectoring cordic arctangent, one lane
// quadrant pre-rotation, one micro-rotation per stage, then a two-stage
// reciprocal conversion from nanoradians to clamped milliradians
// ----------------------------------------------------------------------------
module tsw_cordic_lane (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [tsw_pkg::SPEED_W-1:0]       fwd,
  input  logic signed [tsw_pkg::TERM_W-1:0]        lat,
  output logic signed [tsw_pkg::ANGLE_W-1:0]       angle
);

  localparam int N = tsw_pkg::CORDIC_STEPS;

  logic signed [tsw_pkg::XY_W-1:0] x_r [0:N];
  logic signed [tsw_pkg::XY_W-1:0] y_r [0:N];
  logic signed [tsw_pkg::Z_W-1:0]  z_r [0:N];
  logic                            zero_r [0:N];

  logic signed [tsw_pkg::XY_W-1:0] x0, y0;
  logic signed [tsw_pkg::XY_W-1:0] x_nxt, y_nxt;
  logic signed [tsw_pkg::Z_W-1:0]  z_nxt;

  // scale by 2^24 and fold the left half plane onto the right
  always_comb begin
    x0 = {{(tsw_pkg::XY_W-tsw_pkg::SPEED_W-tsw_pkg::FRAC_W){fwd[tsw_pkg::SPEED_W-1]}},
          fwd, {tsw_pkg::FRAC_W{1'b0}}};
    y0 = {{(tsw_pkg::XY_W-tsw_pkg::TERM_W-tsw_pkg::FRAC_W){lat[tsw_pkg::TERM_W-1]}},
          lat, {tsw_pkg::FRAC_W{1'b0}}};
    x_nxt = x0;
    y_nxt = y0;
    z_nxt = '0;
    if (fwd[tsw_pkg::SPEED_W-1]) begin
      if (!lat[tsw_pkg::TERM_W-1]) begin
        x_nxt = y0;
        y_nxt = -x0;
        z_nxt = tsw_pkg::HALF_PI_NRAD;
      end else begin
        x_nxt = -y0;
        y_nxt = x0;
        z_nxt = -tsw_pkg::HALF_PI_NRAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt;
      y_r[0]    <= y_nxt;
      z_r[0]    <= z_nxt;
      zero_r[0] <= (fwd == '0) && (lat == '0);
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic pos;
    assign pos = !y_r[i][tsw_pkg::XY_W-1] && (y_r[i] != '0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + tsw_pkg::atan_nrad(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - tsw_pkg::atan_nrad(5'(i));
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // nanoradian to milliradian: reciprocal multiply stage
  logic [tsw_pkg::Z_W-1:0]                          zmag;
  logic [tsw_pkg::ZDIV_A_W-1:0]                     za;
  logic [tsw_pkg::ZDIV_A_W-1:0]                     za_r;
  logic [tsw_pkg::ZDIV_A_W+tsw_pkg::ZDIV_M_W-1:0]   zprod_r;
  logic                                             zneg_r;
  logic                                             zzero_r;

  assign zmag = z_r[N][tsw_pkg::Z_W-1] ? -z_r[N] : z_r[N];
  assign za   = zmag[tsw_pkg::ZDIV_PRE +: tsw_pkg::ZDIV_A_W];

  always_ff @(posedge clk) begin
    if (en) begin
      za_r    <= za;
      zprod_r <= za * tsw_pkg::ZDIV_M;
      zneg_r  <= z_r[N][tsw_pkg::Z_W-1];
      zzero_r <= zero_r[N];
    end
  end

  // correct the quotient estimate, clamp and restore the sign; zero in gives angle zero
  localparam int Q_W = tsw_pkg::ZDIV_A_W + tsw_pkg::ZDIV_M_W - tsw_pkg::ZDIV_SHIFT;

  logic [Q_W-1:0]                   q_est, q_fix;
  logic [tsw_pkg::ZDIV_A_W:0]       rem;
  logic [tsw_pkg::ANGLE_W-2:0]      q_clamp;
  logic signed [tsw_pkg::ANGLE_W-1:0] angle_nxt, angle_r;

  always_comb begin
    q_est = zprod_r[tsw_pkg::ZDIV_SHIFT +: Q_W];
    rem   = {1'b0, za_r} - ((tsw_pkg::ZDIV_A_W+1)'(q_est) *
                            (tsw_pkg::ZDIV_A_W+1)'(tsw_pkg::ZDIV_DEN));
    q_fix = (rem >= (tsw_pkg::ZDIV_A_W+1)'(tsw_pkg::ZDIV_DEN)) ? q_est + 1'b1 : q_est;
    q_clamp = (q_fix > Q_W'(tsw_pkg::ANGLE_LIMIT)) ? tsw_pkg::ANGLE_LIMIT
                                                   : q_fix[tsw_pkg::ANGLE_W-2:0];
    if (zzero_r) begin
      angle_nxt = '0;
    end else if (zneg_r) begin
      angle_nxt = -$signed({1'b0, q_clamp});
    end else begin
      angle_nxt = $signed({1'b0, q_clamp});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

// ===== tb/sv/twist_to_steer_wheel_commands_checker.sv =====
// ----------------------------------------------------------------------------
// twist_to_steer_wheel_commands_checker: scoreboard for the steering core
// watches the twist, wheel and register channels, predicts the wheel
// speeds and steering angles of every accepted twist and compares them
// ----------------------------------------------------------------------------
module twist_to_steer_wheel_commands_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // forward_speed[15:0], yaw_rate[31:16]
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [63:0]                    out_tdata,  // front_angle[12:0], front_speed[28:13],
                                                     // rear_angle[41:29], rear_speed[57:42]
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tsw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             n_errors,
  output int                             n_pending
);

  localparam int     ROTATIONS      = (tsw_pkg::ANGLE_ITERATIONS > 24) ? 24 :
                                      tsw_pkg::ANGLE_ITERATIONS;
  localparam longint CORDIC_ONE     = 64'sd16777216;
  localparam longint QUARTER_TURN   = 64'sd1570796327;
  localparam longint NRAD_PER_MRAD  = 64'sd1000000;
  localparam longint ANGLE_MAX_MRAD = 64'sd3142;

  // last field declared sits in the lowest bits, as on the bus
  typedef struct packed {
    logic [tsw_pkg::SPEED_W-1:0] rear_speed;
    logic [tsw_pkg::ANGLE_W-1:0] rear_angle;
    logic [tsw_pkg::SPEED_W-1:0] front_speed;
    logic [tsw_pkg::ANGLE_W-1:0] front_angle;
  } wheel_cmd_t;

  // arctangent of 2^-k in nanoradians
  longint atan_tab [0:23] = '{
    785398163, 463647609, 244978663, 124354995, 62418810, 31239833,
    15623729, 7812341, 3906230, 1953123, 976562, 488281,
    244141, 122070, 61035, 30518, 15259, 7629,
    3815, 1907, 954, 477, 238, 119
  };

  logic [tsw_pkg::WB_W-1:0] base_mm;
  wheel_cmd_t               wheel_q [$];

  function automatic logic [tsw_pkg::ANGLE_W-1:0] steer_angle(input longint fwd,
                                                              input longint lat);
    longint x, y, z, nx, ny, mrad;
    if (fwd == 0 && lat == 0) return '0;
    x = fwd * CORDIC_ONE;
    y = lat * CORDIC_ONE;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      if (y >= 0) begin
        nx = y;
        ny = -x;
        z  = QUARTER_TURN;
      end else begin
        nx = -y;
        ny = x;
        z  = -QUARTER_TURN;
      end
      x = nx;
      y = ny;
    end
    for (int k = 0; k < ROTATIONS; k++) begin
      if (y > 0) begin
        nx = x + (y >>> k);
        ny = y - (x >>> k);
        z  = z + atan_tab[k];
      end else begin
        nx = x - (y >>> k);
        ny = y + (x >>> k);
        z  = z - atan_tab[k];
      end
      x = nx;
      y = ny;
    end
    mrad = z / NRAD_PER_MRAD;
    if (mrad > ANGLE_MAX_MRAD) mrad = ANGLE_MAX_MRAD;
    if (mrad < -ANGLE_MAX_MRAD) mrad = -ANGLE_MAX_MRAD;
    return mrad[tsw_pkg::ANGLE_W-1:0];
  endfunction

  function automatic logic [tsw_pkg::SPEED_W-1:0] clamp_speed(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[tsw_pkg::SPEED_W-1:0];
  endfunction

  function automatic wheel_cmd_t predict_wheels(input logic [31:0] twist,
                                                input logic [tsw_pkg::WB_W-1:0] base);
    longint fwd, yaw, lat;
    wheel_cmd_t c;
    fwd = longint'($signed(twist[15:0]));
    yaw = longint'($signed(twist[31:16]));
    lat = (yaw * longint'(base)) / 2000;
    c.front_angle = steer_angle(fwd, lat);
    c.front_speed = clamp_speed(fwd + lat);
    c.rear_angle  = steer_angle(fwd, -lat);
    c.rear_speed  = clamp_speed(fwd - lat);
    return c;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    wheel_cmd_t got, want;
    if (!rst_n) begin
      base_mm   <= tsw_pkg::WHEEL_BASE_RESET;
      n_pending <= 0;
      wheel_q.delete();
    end else begin
      // word index sits above the byte lane bits
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == tsw_pkg::REG_WHEEL_BASE)
        base_mm <= cfg_pwdata[tsw_pkg::WB_W-1:0];
      if (in_tvalid && in_tready)
        wheel_q.push_back(predict_wheels(in_tdata, base_mm));
      if (out_tvalid && out_tready) begin
        got = out_tdata[57:0];
        if (wheel_q.size() == 0) begin
          $error("wheel transaction with nothing expected: %h", out_tdata);
          n_errors++;
        end else begin
          want = wheel_q.pop_front();
          check_field("front_angle", $signed(want.front_angle), $signed(got.front_angle));
          check_field("front_speed", $signed(want.front_speed), $signed(got.front_speed));
          check_field("rear_angle",  $signed(want.rear_angle),  $signed(got.rear_angle));
          check_field("rear_speed",  $signed(want.rear_speed),  $signed(got.rear_speed));
          check_field("pad", 0, out_tdata[63:58]);
        end
      end
      n_pending <= wheel_q.size();
    end
  end

endmodule

// ===== tb/sv/twist_to_steer_wheel_commands_core_tb.sv =====
// ----------------------------------------------------------------------------
// twist_to_steer_wheel_commands_core_tb: top level of the steering core bench
// drives twists and wheel base settings, stalls the wheel channel at random
// and once for a long stretch, and reports the checker's verdict
// ----------------------------------------------------------------------------
module twist_to_steer_wheel_commands_core_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 200000;
  // settle time after the last wheel transaction, well past the pipe depth
  localparam int TAIL_CYCLES  = 40;
  // long receiver hold, longer than the pipe so the input must back up
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 130;

  localparam logic [tsw_pkg::CFG_ADDR_W-1:0] WHEEL_BASE_ADDR =
    {tsw_pkg::REG_WHEEL_BASE, 2'b00};
  // next register slot, not implemented: writes there must change nothing
  localparam logic [tsw_pkg::CFG_ADDR_W-1:0] SPARE_ADDR      =
    {~tsw_pkg::REG_WHEEL_BASE, 2'b00};

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;   // forward_speed[15:0], yaw_rate[31:16]
  logic                           out_tvalid;
  logic                           out_tready;
  logic [63:0]                    out_tdata;  // front_angle[12:0], front_speed[28:13],
                                              // rear_angle[41:29], rear_speed[57:42]
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [tsw_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]                    cfg_pwdata;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  int   n_errors;
  int   n_pending;

  // control between the twist driver and the wheel-side ready process
  logic no_idle;       // end of run: both sides stream without gaps
  int   hold_req;      // bumped to ask the receiver for one long hold

  twist_to_steer_wheel_commands_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  twist_to_steer_wheel_commands_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .n_errors    (n_errors),
    .n_pending   (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the core hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  // one twist transaction, with an occasional idle burst ahead of it
  task automatic send_twist(input logic [15:0] fwd, input logic [15:0] yaw);
    int gap;
    gap = (!no_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yaw, fwd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted wheel command has come out;
  // the first edge lets the checker count the last accepted twist
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [tsw_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // random twist: mostly full range, with small, zero and corner values mixed
  // in so that zero lateral terms and saturation come up often
  task automatic pick_twist(output logic [15:0] fwd, output logic [15:0] yaw);
    case ($urandom_range(0, 5))
      0, 1: begin
        fwd = 16'($urandom());
        yaw = 16'($urandom());
      end
      2: begin
        fwd = 16'($urandom_range(0, 400)) - 16'd200;
        yaw = 16'($urandom_range(0, 400)) - 16'd200;
      end
      3: begin
        fwd = ($urandom_range(0, 1) == 0) ? 16'h0000 : corner_value();
        yaw = 16'($urandom());
      end
      4: begin
        fwd = 16'($urandom());
        yaw = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(0, 7)) - 16'd3;
      end
      default: begin
        fwd = corner_value();
        yaw = corner_value();
      end
    endcase
  endtask

  // wheel side: ready in random stretches with short stalls, one long hold
  // on request, and no stalls at all once the end of the run is reached
  initial begin
    int hold_seen;
    hold_seen  = 0;
    out_tready <= 1'b0;
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] base_list [5];
    logic [15:0] fwd, yaw;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    no_idle     <= 1'b0;
    hold_req    <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed twists at the reset wheel base of 500 mm
    send_twist(16'd0, 16'd0);                 // both zero: angle 0
    send_twist(-16'sd100, 16'd0);             // backward, no yaw: angle pi
    send_twist(-16'sd5, -16'sd3);             // yaw truncates to a zero term
    send_twist(16'sd100, 16'sd3);
    send_twist(16'h7FFF, 16'h7FFF);           // front speed saturates high
    send_twist(16'h8000, 16'h8000);           // front speed saturates low
    send_twist(16'h7FFF, 16'h8000);
    send_twist(16'h8000, 16'h7FFF);
    send_twist(16'h7FFF, 16'd0);
    send_twist(16'h8000, 16'd0);
    send_twist(16'd0, 16'h7FFF);              // pure yaw: plus and minus pi/2
    send_twist(16'd0, 16'h8000);
    send_twist(16'd0, 16'sd1000);
    send_twist(16'd0, -16'sd1000);
    send_twist(16'sd1, 16'sd1);
    send_twist(-16'sd1, -16'sd1);
    send_twist(16'sd1000, 16'sd4000);         // term equals forward: pi/4
    send_twist(-16'sd1000, 16'sd4000);        // left half plane, both signs
    send_twist(-16'sd1000, -16'sd4000);
    drain();

    // unmapped register: the wheel base stays at 500
    reg_write(SPARE_ADDR, $urandom());
    send_twist(16'sd1000, 16'sd4000);
    send_twist(-16'sd300, 16'sd2000);
    drain();

    // zero wheel base: no lateral term, speeds follow forward speed
    reg_write(WHEEL_BASE_ADDR, {16'($urandom()), 16'd0});
    send_twist(16'sd1000, 16'sd4000);
    send_twist(-16'sd1000, 16'h7FFF);
    send_twist(16'h7FFF, 16'h8000);
    drain();

    // random phases over the wheel base range, extremes included
    base_list = '{16'hFFFF, 16'd1, 16'd2000, 16'($urandom_range(1, 65535)), 16'd500};
    foreach (base_list[p]) begin
      drain();
      reg_write(WHEEL_BASE_ADDR, {16'($urandom()), base_list[p]});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long wheel-side hold while twists keep coming, fills the pipe
        if (p == 0 && i == 40) hold_req <= hold_req + 1;
        // last stretch runs back to back on both sides
        if (p == 4 && i == 60) no_idle <= 1'b1;
        pick_twist(fwd, yaw);
        send_twist(fwd, yaw);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tsw_pkg.sv
sv/tsw_cordic_lane.sv
sv/twist_to_steer_wheel_commands_core.sv
tb/sv/twist_to_steer_wheel_commands_checker.sv
tb/sv/twist_to_steer_wheel_commands_core_tb.sv
